// ===== src/fba_pkg.sv =====
`timescale 1ns / 1ps

package fba_pkg;

  localparam int MAX_FRAMES_DEF  = 32768;
  localparam int WORD_BITS_DEF   = 32;
  localparam int FRAME_W         = 15;
  localparam int FRAME_LIMIT     = 32768;
  localparam int CFG_W           = 16;
  localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 16'd32768;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_TEST  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MAPPED  = 2'd2,
    STAT_NOTHING = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_REM,
    S_UPD,
    S_SCAN
  } state_t;

  typedef struct packed {
    func_t              func;
    logic [FRAME_W-1:0] frame_number;
    logic               kernel_page;
    logic               writable;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_out;
    logic               present_bit;
    logic               rw_bit;
    logic               user_bit;
    logic               is_used;
    status_t            status;
  } rsp_t;

endpackage

// ===== src/fba_bitmap_ram.sv =====
`timescale 1ns / 1ps

module fba_bitmap_ram #(
  parameter int Depth = 1024,
  parameter int Width = 32,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/fba_first_zero.sv =====
`timescale 1ns / 1ps

// Lowest clear bit among the lowest `count` bits of a bitmap word.
module fba_first_zero #(
  parameter int Width = 32,
  parameter int BW    = 5,
  parameter int CW    = 6
) (
  input  logic [Width-1:0] word,
  input  logic [CW-1:0]    count,
  output logic             found,
  output logic [BW-1:0]    idx
);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = Width - 1; i >= 0; i--) begin
      if ((CW'(i) < count) && !word[i]) begin
        found = 1'b1;
        idx   = BW'(i);
      end
    end
  end

endmodule

// ===== src/frame_bitmap_allocator.sv =====
`timescale 1ns / 1ps

// Allocate reads bitmap words from the low-water word on; free and test go through the divide,
// remainder and update states; already-mapped, full-at-low-water, bad-range and unused requests raise
// done in the next cycle. Throughput: one transaction at a time; the bitmap RAM read-modify-write loop
// sets the pace. Reset: after rst drops, a clearing pass writes every bitmap word to zero, one word per
// cycle; busy stays high during it. Results cannot be stalled.
module frame_bitmap_allocator #(
  parameter int MAX_FRAMES       = fba_pkg::MAX_FRAMES_DEF,
  parameter int BITMAP_WORD_BITS = fba_pkg::WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  fba_pkg::req_t              req,
  input  logic                       cfg_we,
  input  logic [fba_pkg::CFG_W-1:0]  cfg_wdata,
  output logic                       done,
  output fba_pkg::rsp_t              rsp
);

  localparam int W          = BITMAP_WORD_BITS;
  localparam int WordCount  = (MAX_FRAMES + W - 1) / W;
  localparam int AW         = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam int BW         = $clog2(W);
  localparam int CW         = $clog2(W + 1);
  localparam int BaseW      = $clog2(MAX_FRAMES + W + 1);
  localparam int FW         = fba_pkg::FRAME_W;
  localparam int CmpW       = (BaseW > fba_pkg::CFG_W) ? BaseW : fba_pkg::CFG_W;
  localparam int LimitFrames =
    (MAX_FRAMES < fba_pkg::FRAME_LIMIT) ? MAX_FRAMES : fba_pkg::FRAME_LIMIT;
  // frame / W as multiply by reciprocal, exact for all 15-bit frames
  localparam int RecipShift = FW + BW;
  localparam int RecipW     = RecipShift + 1;
  localparam int ProdW      = FW + RecipW;
  localparam logic [RecipW-1:0] Recip = RecipW'(((1 << RecipShift) + W - 1) / W);

  fba_pkg::state_t state, state_next;
  logic [fba_pkg::CFG_W-1:0] frame_count;
  fba_pkg::req_t             op, op_next;
  logic [AW-1:0]             lw_addr, lw_addr_next;
  logic [BaseW-1:0]          lw_base, lw_base_next;
  logic [AW-1:0]             scan_addr, scan_addr_next;
  logic [BaseW-1:0]          scan_base, scan_base_next;
  logic [AW-1:0]             word_addr, word_addr_next;
  logic [BaseW-1:0]          word_base, word_base_next;
  logic [BW-1:0]             bit_idx, bit_idx_next;
  logic [AW-1:0]             clr_addr, clr_addr_next;
  logic                      done_next;
  fba_pkg::rsp_t             rsp_next;

  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [W-1:0]              ram_wdata, ram_rdata;

  logic [fba_pkg::CFG_W-1:0] usable;
  logic [CmpW-1:0]           usable_ext;
  logic [CmpW-1:0]           remaining;
  logic [CW-1:0]             valid_cnt;
  logic                      fz_found;
  logic [BW-1:0]             fz_idx;
  logic [BaseW-1:0]          next_base;
  logic [ProdW-1:0]          prod;
  logic [FW-1:0]             word_first;
  logic                      in_range;

  assign usable = (frame_count > fba_pkg::CFG_W'(LimitFrames)) ?
                  fba_pkg::CFG_W'(LimitFrames) : frame_count;
  assign usable_ext = CmpW'(usable);
  assign remaining  = usable_ext - CmpW'(scan_base);
  assign valid_cnt  = (remaining > CmpW'(W)) ? CW'(W) : CW'(remaining);
  assign next_base  = scan_base + BaseW'(W);
  assign prod       = ProdW'(op.frame_number) * ProdW'(Recip);
  assign word_first = FW'(CmpW'(word_addr) * CmpW'(W));
  assign in_range   = CmpW'(req.frame_number) < CmpW'(MAX_FRAMES);
  assign busy       = (state != fba_pkg::S_IDLE);

  fba_bitmap_ram #(
    .Depth (WordCount),
    .Width (W),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fba_first_zero #(
    .Width (W),
    .BW    (BW),
    .CW    (CW)
  ) u_first_zero (
    .word  (ram_rdata),
    .count (valid_cnt),
    .found (fz_found),
    .idx   (fz_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fba_pkg::S_CLEAR;
      frame_count <= fba_pkg::FRAME_COUNT_RST;
      lw_addr     <= '0;
      lw_base     <= '0;
      clr_addr    <= '0;
      done        <= 1'b0;
    end else begin
      state    <= state_next;
      lw_addr  <= lw_addr_next;
      lw_base  <= lw_base_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
      if (cfg_we) begin
        frame_count <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    scan_addr <= scan_addr_next;
    scan_base <= scan_base_next;
    word_addr <= word_addr_next;
    word_base <= word_base_next;
    bit_idx   <= bit_idx_next;
    rsp       <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    lw_addr_next   = lw_addr;
    lw_base_next   = lw_base;
    scan_addr_next = scan_addr;
    scan_base_next = scan_base;
    word_addr_next = word_addr;
    word_base_next = word_base;
    bit_idx_next   = bit_idx;
    clr_addr_next  = clr_addr;
    done_next      = 1'b0;
    rsp_next       = rsp;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    case (state)
      fba_pkg::S_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(WordCount - 1)) begin
          state_next = fba_pkg::S_IDLE;
        end
      end

      fba_pkg::S_IDLE: begin
        if (start) begin
          op_next = req;
          case (req.func)
            fba_pkg::FUNC_ALLOC: begin
              if (req.frame_number != '0) begin
                done_next          = 1'b1;
                rsp_next           = '0;
                rsp_next.frame_out = req.frame_number;
                rsp_next.status    = fba_pkg::STAT_MAPPED;
              end else if (CmpW'(lw_base) >= usable_ext) begin
                // everything below the low-water word is in use
                done_next       = 1'b1;
                rsp_next        = '0;
                rsp_next.status = fba_pkg::STAT_FULL;
              end else begin
                ram_re         = 1'b1;
                ram_raddr      = lw_addr;
                scan_addr_next = lw_addr;
                scan_base_next = lw_base;
                state_next     = fba_pkg::S_SCAN;
              end
            end
            fba_pkg::FUNC_FREE: begin
              if (req.frame_number == '0) begin
                done_next       = 1'b1;
                rsp_next        = '0;
                rsp_next.status = fba_pkg::STAT_NOTHING;
              end else if (!in_range) begin
                done_next = 1'b1;
                rsp_next  = '0;
              end else begin
                state_next = fba_pkg::S_DIV;
              end
            end
            fba_pkg::FUNC_TEST: begin
              if (!in_range) begin
                done_next          = 1'b1;
                rsp_next           = '0;
                rsp_next.frame_out = req.frame_number;
              end else begin
                state_next = fba_pkg::S_DIV;
              end
            end
            default: begin
              done_next = 1'b1;
              rsp_next  = '0;
            end
          endcase
        end
      end

      fba_pkg::S_DIV: begin
        word_addr_next = AW'(prod[RecipShift +: FW + 1]);
        state_next     = fba_pkg::S_REM;
      end

      fba_pkg::S_REM: begin
        bit_idx_next   = BW'(op.frame_number - word_first);
        word_base_next = BaseW'(word_first);
        ram_re         = 1'b1;
        ram_raddr      = word_addr;
        state_next     = fba_pkg::S_UPD;
      end

      fba_pkg::S_UPD: begin
        done_next  = 1'b1;
        rsp_next   = '0;
        state_next = fba_pkg::S_IDLE;
        if (op.func == fba_pkg::FUNC_FREE) begin
          ram_we    = 1'b1;
          ram_waddr = word_addr;
          ram_wdata = ram_rdata & ~(W'(1) << bit_idx);
          if (word_addr < lw_addr) begin
            lw_addr_next = word_addr;
            lw_base_next = word_base;
          end
        end else begin
          rsp_next.frame_out = op.frame_number;
          rsp_next.is_used   = ram_rdata[bit_idx];
        end
      end

      fba_pkg::S_SCAN: begin
        if (fz_found) begin
          ram_we               = 1'b1;
          ram_waddr            = scan_addr;
          ram_wdata            = ram_rdata | (W'(1) << fz_idx);
          done_next            = 1'b1;
          rsp_next             = '0;
          rsp_next.frame_out   = FW'(scan_base + BaseW'(fz_idx));
          rsp_next.present_bit = 1'b1;
          rsp_next.rw_bit      = op.writable;
          rsp_next.user_bit    = !op.kernel_page;
          lw_addr_next         = scan_addr;
          lw_base_next         = scan_base;
          state_next           = fba_pkg::S_IDLE;
        end else if (CmpW'(next_base) >= usable_ext) begin
          done_next       = 1'b1;
          rsp_next        = '0;
          rsp_next.status = fba_pkg::STAT_FULL;
          lw_addr_next    = scan_addr;
          lw_base_next    = scan_base;
          state_next      = fba_pkg::S_IDLE;
        end else begin
          // whole word in use: move on
          ram_re         = 1'b1;
          ram_raddr      = scan_addr + AW'(1);
          scan_addr_next = scan_addr + AW'(1);
          scan_base_next = next_base;
        end
      end

      default: begin
        state_next = fba_pkg::S_IDLE;
      end
    endcase
  end

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transaction neither busy nor done");

  a_lw_consistent: assert property (@(posedge clk) disable iff (rst)
    lw_base == BaseW'(CmpW'(lw_addr) * CmpW'(W)))
    else $error("low-water base out of step with its word address");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == fba_pkg::S_SCAN) |-> (CmpW'(scan_base) < usable_ext))
    else $error("scan went past the usable frame count");

  a_present_ok: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.present_bit) |-> (rsp.status == fba_pkg::STAT_OK && !rsp.is_used))
    else $error("present flag with a non-ok status");

  a_no_done_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == fba_pkg::S_CLEAR) |=> !done)
    else $error("result strobe during the clearing pass");

endmodule
